### rtl/trd_pkg.sv
// Package for the TGA run-length pixel decoder: payload types, codes and helpers.
`timescale 1ns / 1ps

package trd_pkg;

    // Packet header fields and the opaque alpha value
    localparam logic [7:0] RLE_COUNT_MASK = 8'h7f;
    localparam logic [7:0] RLE_RUN_BIT    = 8'h80;
    localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;

    // Pixel format codes
    localparam logic [1:0] FMT_16 = 2'd0;
    localparam logic [1:0] FMT_24 = 2'd1;
    localparam logic [1:0] FMT_32 = 2'd2;

    // Configuration register indexes
    localparam logic CFG_PIXEL_FORMAT = 1'b0;
    localparam logic CFG_TOTAL_PIXELS = 1'b1;

    // Reset values of the configuration registers
    localparam logic [1:0]  PIXEL_FORMAT_RST = FMT_32;
    localparam logic [31:0] TOTAL_PIXELS_RST = 32'd0;

    // Decode status codes
    typedef enum logic [1:0] {
        ST_PROGRESS   = 2'd0,
        ST_COMPLETE   = 2'd1,
        ST_INCOMPLETE = 2'd2
    } t_status;

    // One input byte
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_item;

    // One result
    typedef struct packed {
        logic [31:0] pixel_word;
        logic [7:0]  repeat_count;
        logic        pixel_valid;
        logic [1:0]  decode_status;
    } t_out_item;

    // Bytes per source pixel; the unused code decodes as 32-bit
    function automatic logic [2:0] bytes_per_pixel(input logic [1:0] fmt);
        logic [2:0] bpp;
        begin
            case (fmt)
                FMT_16:  bpp = 3'd2;
                FMT_24:  bpp = 3'd3;
                default: bpp = 3'd4;
            endcase
            return bpp;
        end
    endfunction

endpackage

### rtl/trd_core.sv
// Decode state and per-byte step logic of the TGA run-length pixel decoder.
`timescale 1ns / 1ps

module trd_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_go,
    input  trd_pkg::t_in_item   i_item,
    input  logic [1:0]          i_pixel_format,
    input  logic [31:0]         i_total_pixels,
    output logic                o_res_valid,
    output trd_pkg::t_out_item  o_res
);

    logic        r_expect_header, n_expect_header;
    logic        r_packet_is_run, n_packet_is_run;
    logic [7:0]  r_packet_left,   n_packet_left;
    logic [1:0]  r_byte_position, n_byte_position;
    logic [31:0] r_pixel_assembly, n_pixel_assembly;
    logic [31:0] r_pixels_done,   n_pixels_done;
    logic        r_finished,      n_finished;

    logic [31:0] assembled;
    logic [1:0]  pos_next;
    logic [2:0]  bpp;
    logic [31:0] remaining;
    logic [7:0]  rep;
    logic [31:0] done_next;
    logic [31:0] word;

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_header  <= 1'b1;
            r_packet_is_run  <= 1'b0;
            r_packet_left    <= 8'd0;
            r_byte_position  <= 2'd0;
            r_pixel_assembly <= 32'd0;
            r_pixels_done    <= 32'd0;
            r_finished       <= 1'b0;
        end else if (i_go) begin
            r_expect_header  <= n_expect_header;
            r_packet_is_run  <= n_packet_is_run;
            r_packet_left    <= n_packet_left;
            r_byte_position  <= n_byte_position;
            r_pixel_assembly <= n_pixel_assembly;
            r_pixels_done    <= n_pixels_done;
            r_finished       <= n_finished;
        end
    end

    // Byte lane insert into the pixel being assembled
    always_comb begin
        assembled = r_pixel_assembly;
        case (r_byte_position)
            2'd0:    assembled[7:0]   = r_pixel_assembly[7:0]   | i_item.data_byte;
            2'd1:    assembled[15:8]  = r_pixel_assembly[15:8]  | i_item.data_byte;
            2'd2:    assembled[23:16] = r_pixel_assembly[23:16] | i_item.data_byte;
            default: assembled[31:24] = r_pixel_assembly[31:24] | i_item.data_byte;
        endcase
    end

    assign pos_next  = r_byte_position + 2'd1;
    assign bpp       = trd_pkg::bytes_per_pixel(i_pixel_format);
    assign remaining = i_total_pixels - r_pixels_done;

    // Run length clipped to the pixels still missing
    always_comb begin
        if (!r_packet_is_run) begin
            rep = 8'd1;
        end else if ({24'd0, r_packet_left} > remaining) begin
            rep = remaining[7:0];
        end else begin
            rep = r_packet_left;
        end
    end

    assign done_next = r_pixels_done + {24'd0, rep};

    // Format the finished pixel
    always_comb begin
        case (bpp)
            3'd2:    word = {16'd0, assembled[15:0]};
            3'd3:    word = {trd_pkg::ALPHA_OPAQUE, assembled[23:0]};
            default: word = assembled;
        endcase
    end

    // Next state and result
    always_comb begin
        n_expect_header  = r_expect_header;
        n_packet_is_run  = r_packet_is_run;
        n_packet_left    = r_packet_left;
        n_byte_position  = r_byte_position;
        n_pixel_assembly = r_pixel_assembly;
        n_pixels_done    = r_pixels_done;
        n_finished       = r_finished;
        o_res_valid      = 1'b0;
        o_res            = '0;

        if (r_finished) begin
            // decode over: bytes are dropped
            o_res_valid = 1'b0;
        end else if (r_pixels_done >= i_total_pixels) begin
            // nothing left to decode
            n_finished          = 1'b1;
            o_res_valid         = 1'b1;
            o_res.decode_status = trd_pkg::ST_COMPLETE;
        end else if (r_expect_header) begin
            n_packet_left    = (i_item.data_byte & trd_pkg::RLE_COUNT_MASK) + 8'd1;
            n_packet_is_run  = (i_item.data_byte & trd_pkg::RLE_RUN_BIT) != 8'd0;
            n_expect_header  = 1'b0;
            n_byte_position  = 2'd0;
            n_pixel_assembly = 32'd0;
            if (i_item.last_byte) begin
                n_finished          = 1'b1;
                o_res_valid         = 1'b1;
                o_res.decode_status = trd_pkg::ST_INCOMPLETE;
            end
        end else if (pos_next != 2'd0 && {1'b0, pos_next} < bpp) begin
            // pixel still partial
            n_pixel_assembly = assembled;
            n_byte_position  = pos_next;
            if (i_item.last_byte) begin
                n_finished          = 1'b1;
                o_res_valid         = 1'b1;
                o_res.decode_status = trd_pkg::ST_INCOMPLETE;
            end
        end else begin
            // pixel finished
            n_byte_position  = 2'd0;
            n_pixel_assembly = 32'd0;
            if (r_packet_is_run) begin
                n_packet_left   = 8'd0;
                n_expect_header = 1'b1;
            end else begin
                n_packet_left   = r_packet_left - 8'd1;
                n_expect_header = (r_packet_left == 8'd1);
            end
            n_pixels_done      = done_next;
            o_res_valid        = 1'b1;
            o_res.pixel_word   = word;
            o_res.repeat_count = rep;
            o_res.pixel_valid  = 1'b1;
            if (done_next >= i_total_pixels) begin
                n_finished          = 1'b1;
                o_res.decode_status = trd_pkg::ST_COMPLETE;
            end else if (i_item.last_byte) begin
                n_finished          = 1'b1;
                o_res.decode_status = trd_pkg::ST_INCOMPLETE;
            end else begin
                o_res.decode_status = trd_pkg::ST_PROGRESS;
            end
        end
    end

endmodule

### rtl/trd_out_reg.sv
// Result register of the TGA run-length pixel decoder.
`timescale 1ns / 1ps

module trd_out_reg (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  trd_pkg::t_out_item  i_res,
    input  logic                i_out_stall,
    output logic                o_free,
    output logic                o_out_valid,
    output trd_pkg::t_out_item  o_out_data
);

    logic               r_valid;
    trd_pkg::t_out_item r_data;

    // Register can take a result when empty or being drained this cycle
    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

### rtl/tga_rle_pixel_decoder.sv
// Top level of the TGA run-length pixel decoder: input register, config and result path.
// A byte transfer is captured in the input register; the decode step takes it from there
// and loads its result, if any, into the output register, which makes the result transfer.
// Throughput: one byte per cycle, set by the combinational decode step between the input
// register and the result register; a result held by a stalled output holds every byte.
// Reset (synchronous, active low): empty pipeline, header expected, 32-bit BGRA, total 0.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input byte channel
    input  logic                i_in_valid,
    input  trd_pkg::t_in_item   i_in_data,
    output logic                o_in_stall,
    // result channel
    output logic                o_out_valid,
    output trd_pkg::t_out_item  o_out_data,
    input  logic                i_out_stall,
    // configuration write channel
    input  logic                i_cfg_valid,
    input  logic                i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output logic                o_cfg_ready
);

    logic               r_in_valid;
    trd_pkg::t_in_item  r_in_item;
    logic [1:0]         r_pixel_format;
    logic [31:0]        r_total_pixels;

    logic               out_free;
    logic               go;
    logic               res_valid;
    trd_pkg::t_out_item res;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_format <= trd_pkg::PIXEL_FORMAT_RST;
            r_total_pixels <= trd_pkg::TOTAL_PIXELS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                trd_pkg::CFG_PIXEL_FORMAT: r_pixel_format <= i_cfg_data[1:0];
                trd_pkg::CFG_TOTAL_PIXELS: r_total_pixels <= i_cfg_data;
                default:                   r_total_pixels <= r_total_pixels;
            endcase
        end
    end

    // Decode step fires when a byte is held and the result register can take it
    assign go         = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (go) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_data;
        end
    end

    trd_core u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_go           (go),
        .i_item         (r_in_item),
        .i_pixel_format (r_pixel_format),
        .i_total_pixels (r_total_pixels),
        .o_res_valid    (res_valid),
        .o_res          (res)
    );

    trd_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (go && res_valid),
        .i_res       (res),
        .i_out_stall (i_out_stall),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule

### tb/sv/tga_rle_pixel_checker.sv
// Checker for the TGA run-length pixel decoder: decodes each byte transfer and compares results.
`timescale 1ns / 1ps

module tga_rle_pixel_checker
    import trd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte channel, observed
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in_item    i_in_data,
    // result channel, observed
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out_item   i_out_data,
    // configuration write channel, observed
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    // status for the stimulus side
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output logic [31:0] o_pixels_done,
    output logic        o_finished
);

    // Decoder copy of the configuration
    logic [1:0]  fmt_cfg;
    logic [31:0] total_cfg;

    // Decoder state
    logic        want_header;
    logic        run_packet;
    logic [7:0]  pixels_left;
    logic [1:0]  byte_idx;
    logic [31:0] pixel_acc;
    logic [31:0] pixels_done;
    logic        image_ended;

    t_out_item   decoded_q[$];
    t_out_item   want;
    int          mismatches = 0;
    int          results_checked = 0;
    int          results_due = 0;

    assign o_fail_count  = mismatches;
    assign o_pending     = results_due;
    assign o_checked     = results_checked;
    assign o_pixels_done = pixels_done;
    assign o_finished    = image_ended;

    initial begin
        pixels_done = '0;
        image_ended = 1'b0;
    end

    function automatic void post_result(input logic [31:0] word, input logic [7:0] rep,
                                        input logic has_pixel, input t_status st);
        t_out_item r;
        r.pixel_word    = word;
        r.repeat_count  = rep;
        r.pixel_valid   = has_pixel;
        r.decode_status = st;
        decoded_q.push_back(r);
    endfunction

    // Decode one byte and queue the result it causes, if any
    function automatic void decode_byte(input t_in_item item);
        logic [7:0]  b;
        logic        is_last;
        logic [2:0]  pixel_bytes;
        logic [31:0] word;
        logic [31:0] rep;
        logic [31:0] missing;
        t_status     st;
        b       = item.data_byte;
        is_last = item.last_byte;

        if (image_ended) return;

        // nothing left to decode: swallow the byte and report completion
        if (pixels_done >= total_cfg) begin
            image_ended = 1'b1;
            post_result('0, '0, 1'b0, ST_COMPLETE);
            return;
        end

        if (want_header) begin
            pixels_left = (b & RLE_COUNT_MASK) + 8'd1;
            run_packet  = (b & RLE_RUN_BIT) != 8'd0;
            want_header = 1'b0;
            byte_idx    = '0;
            pixel_acc   = '0;
            if (is_last) begin
                image_ended = 1'b1;
                post_result('0, '0, 1'b0, ST_INCOMPLETE);
            end
            return;
        end

        pixel_acc = pixel_acc | ({24'd0, b} << (8 * byte_idx));
        byte_idx  = byte_idx + 2'd1;
        case (fmt_cfg)
            FMT_16:  pixel_bytes = 3'd2;
            FMT_24:  pixel_bytes = 3'd3;
            default: pixel_bytes = 3'd4;
        endcase

        // pixel still partial; the size of the current format decides
        if (byte_idx != 2'd0 && {1'b0, byte_idx} < pixel_bytes) begin
            if (is_last) begin
                image_ended = 1'b1;
                post_result('0, '0, 1'b0, ST_INCOMPLETE);
            end
            return;
        end

        case (fmt_cfg)
            FMT_16:  word = pixel_acc & 32'h0000_FFFF;
            FMT_24:  word = (pixel_acc & 32'h00FF_FFFF) | {ALPHA_OPAQUE, 24'd0};
            default: word = pixel_acc;
        endcase
        byte_idx  = '0;
        pixel_acc = '0;

        if (run_packet) begin
            // clip a run that goes past the end of the image
            missing = total_cfg - pixels_done;
            rep     = {24'd0, pixels_left};
            if (rep > missing) rep = missing;
            pixels_left = '0;
            want_header = 1'b1;
        end else begin
            rep         = 32'd1;
            pixels_left = pixels_left - 8'd1;
            if (pixels_left == 8'd0) want_header = 1'b1;
        end
        pixels_done = pixels_done + rep;

        if (pixels_done >= total_cfg) begin
            st          = ST_COMPLETE;
            image_ended = 1'b1;
        end else if (is_last) begin
            st          = ST_INCOMPLETE;
            image_ended = 1'b1;
        end else begin
            st = ST_PROGRESS;
        end
        post_result(word, rep[7:0], 1'b1, st);
    endfunction

    // Watch all three channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            fmt_cfg     = PIXEL_FORMAT_RST;
            total_cfg   = TOTAL_PIXELS_RST;
            want_header = 1'b1;
            run_packet  = 1'b0;
            pixels_left = '0;
            byte_idx    = '0;
            pixel_acc   = '0;
            pixels_done = '0;
            image_ended = 1'b0;
            decoded_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_PIXEL_FORMAT) fmt_cfg = i_cfg_data[1:0];
                else total_cfg = i_cfg_data;
            end

            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("result transfer with no decoded result due");
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    results_checked++;
                    if (i_out_data.pixel_word !== want.pixel_word) begin
                        $error("pixel_word: expected %h, got %h",
                               want.pixel_word, i_out_data.pixel_word);
                        mismatches++;
                    end
                    if (i_out_data.repeat_count !== want.repeat_count) begin
                        $error("repeat_count: expected %0d, got %0d",
                               want.repeat_count, i_out_data.repeat_count);
                        mismatches++;
                    end
                    if (i_out_data.pixel_valid !== want.pixel_valid) begin
                        $error("pixel_valid: expected %b, got %b",
                               want.pixel_valid, i_out_data.pixel_valid);
                        mismatches++;
                    end
                    if (i_out_data.decode_status !== want.decode_status) begin
                        $error("decode_status: expected %0d, got %0d",
                               want.decode_status, i_out_data.decode_status);
                        mismatches++;
                    end
                end
            end

            if (i_in_valid && !i_in_stall) decode_byte(i_in_data);
        end
        results_due = decoded_q.size();
    end

endmodule

### tb/sv/tga_rle_pixel_decoder_test.sv
// Testbench top for the TGA run-length pixel decoder: clock, reset, byte stimulus and verdict.
`timescale 1ns / 1ps

module tga_rle_pixel_decoder_test;

    import trd_pkg::*;

    localparam int         CYCLE_LIMIT   = 300000;
    localparam int         BLOCK_LATENCY = 2;
    localparam int         RANDOM_BYTES  = 1300;
    localparam logic [1:0] FMT_SPARE     = 2'd3;

    typedef enum int {END_CLIP, END_LOWER, END_EARLY} t_ending;

    logic        i_clk = 1'b0;
    logic        i_rst_n;

    logic        in_valid;
    t_in_item    in_data;
    logic        in_stall;
    logic        out_valid;
    t_out_item   out_data;
    logic        out_stall;
    logic        cfg_valid;
    logic        cfg_index;
    logic [31:0] cfg_data;
    logic        cfg_ready;

    int          fail_count;
    int          pending;
    int          checked;
    logic [31:0] pixels_done;
    logic        decode_finished;

    logic        calm = 1'b0;
    logic [1:0]  fmt_now;
    int          bytes_sent = 0;
    int          phase_count = 0;
    int          end_countdown = 0;
    int          cycle_count = 0;
    t_ending     ending;

    tga_rle_pixel_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    tga_rle_pixel_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_data     (in_data),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_data    (out_data),
        .i_cfg_valid   (cfg_valid),
        .i_cfg_ready   (cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_pixels_done (pixels_done),
        .o_finished    (decode_finished)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: random stall ahead of each result transfer
    initial begin : result_sink
        int hold;
        out_stall = 1'b0;
        @(negedge i_clk);
        forever begin
            hold = calm ? 0 : $urandom_range(0, 7);
            if (hold > 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            out_stall <= 1'b0;
            @(posedge i_clk);
            while (!out_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // One byte transfer, after a random gap; returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= {b, is_last};
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // Byte of the packet stream; marks the source end when the countdown runs out
    task automatic feed(input logic [7:0] b);
        logic is_last;
        is_last = (end_countdown == 1);
        if (end_countdown > 0) end_countdown--;
        send_byte(b, is_last);
    endtask

    // Well-formed packet with random content, mostly short
    task automatic send_packet();
        int   count;
        int   n;
        logic run;
        count = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(1, 128);
        run   = 1'($urandom_range(0, 1));
        n     = run ? bytes_per_pixel(fmt_now) : count * bytes_per_pixel(fmt_now);
        feed({run, 7'(count - 1)});
        for (int i = 0; i < n && !decode_finished; i++) feed(8'($urandom_range(0, 255)));
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_format(input logic [1:0] f);
        write_reg(CFG_PIXEL_FORMAT, {30'($urandom), f});
        fmt_now = f;
    endtask

    // Hold the sender until every due result is out and the pipeline is empty
    task automatic settle();
        in_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (2 * BLOCK_LATENCY) @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [1:0] fmt_order [4];
        int         phase_end;
        fmt_order = '{FMT_16, FMT_24, FMT_SPARE, FMT_32};
        i_rst_n   = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_PIXEL_FORMAT;
        cfg_data  = '0;
        fmt_now   = PIXEL_FORMAT_RST;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: keep the image open, cover each format and packet extreme
        write_reg(CFG_TOTAL_PIXELS, 32'd0);
        write_reg(CFG_TOTAL_PIXELS, 32'hFFFF_FFFF);
        // 32-bit run of 128, all ones
        send_byte(8'hFF, 1'b0);
        repeat (4) send_byte(8'hFF, 1'b0);
        settle();
        // 16-bit raw of 2
        set_format(FMT_16);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h34, 1'b0); send_byte(8'h12, 1'b0);
        settle();
        // 24-bit run of 127, alpha filled in
        set_format(FMT_24);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h01, 1'b0); send_byte(8'h02, 1'b0); send_byte(8'h03, 1'b0);
        settle();
        // format switched to 16-bit with two bytes of a 32-bit pixel taken
        set_format(FMT_32);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b0); send_byte(8'h55, 1'b0);
        settle();
        set_format(FMT_16);
        send_byte(8'h5A, 1'b0);
        settle();
        // unused format code, run of 1
        set_format(FMT_SPARE);
        send_byte(8'h80, 1'b0);
        send_byte(8'h0F, 1'b0); send_byte(8'hF0, 1'b0);
        send_byte(8'hC3, 1'b0); send_byte(8'h3C, 1'b0);

        // Random phases, each drained before its register writes
        while (bytes_sent < RANDOM_BYTES) begin
            settle();
            calm = ($urandom_range(0, 3) == 0);
            set_format(phase_count < 4 ? fmt_order[phase_count] : 2'($urandom_range(0, 3)));
            case ($urandom_range(0, 3))
                0: write_reg(CFG_TOTAL_PIXELS, 32'hFFFF_FFFF);
                1: write_reg(CFG_TOTAL_PIXELS, 32'h8000_0000 | $urandom);
                2: write_reg(CFG_TOTAL_PIXELS,
                             pixels_done + 32'h0010_0000 + $urandom_range(0, 32'hFFFF));
                default: ;
            endcase
            phase_end = bytes_sent + $urandom_range(80, 220);
            while (bytes_sent < phase_end) send_packet();
            phase_count++;
        end
        settle();

        // One way to end the image; reset comes only once
        calm   = 1'b0;
        ending = t_ending'($urandom_range(0, 2));
        case (ending)
            END_CLIP:  write_reg(CFG_TOTAL_PIXELS, pixels_done + $urandom_range(1, 8));
            END_LOWER: write_reg(CFG_TOTAL_PIXELS,
                                 $urandom_range(0, 1) ? 32'd0 : $urandom_range(0, pixels_done));
            default:   end_countdown = $urandom_range(1, 40);
        endcase
        while (!decode_finished) send_packet();

        // Everything after the end is dropped
        send_byte(8'($urandom), 1'b1);
        send_byte(8'($urandom), 1'b0);
        repeat (10) send_byte(8'($urandom), 1'($urandom));
        settle();

        $display("%0d bytes in %0d random phases, %0d results checked",
                 bytes_sent, phase_count, checked);
        $display("image ended by %s after %0d pixels", ending.name(), pixels_done);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/trd_pkg.sv
rtl/trd_core.sv
rtl/trd_out_reg.sv
rtl/tga_rle_pixel_decoder.sv
tb/sv/tga_rle_pixel_checker.sv
tb/sv/tga_rle_pixel_decoder_test.sv
